[rtl/sdcd_pkg.sv]
// ----------------------------------------------------------------------------
// sdcd_pkg
// Shared types, codes and defaults of the serial drive command decoder.
// ----------------------------------------------------------------------------
package sdcd_pkg;

   // default line buffer length
   localparam int LINE_LIMIT_DEF = 30;

   // register reset values
   localparam logic [7:0] MIN_PWM_RST    = 8'd60;
   localparam logic [7:0] MAX_PWM_RST    = 8'd220;
   localparam logic [7:0] TURN_PWM_RST   = 8'd150;
   localparam logic [6:0] RAMP_STEPS_RST = 7'd20;
   localparam logic [6:0] RAMP_STEPS_MAX = 7'd64;

   // number saturation limit
   localparam logic [9:0] NUM_SAT = 10'd1023;

   // register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_PWM    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PWM    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TURN_PWM   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RAMP_STEPS = 2'd3;

   // motor direction codes
   localparam logic [1:0] DIR_FWD = 2'd0;
   localparam logic [1:0] DIR_BWD = 2'd1;
   localparam logic [1:0] DIR_BRK = 2'd2;

   // characters
   localparam logic [7:0] CHAR_LF    = 8'd10;
   localparam logic [7:0] CHAR_CR    = 8'd13;
   localparam logic [7:0] CHAR_TAB   = 8'd9;
   localparam logic [7:0] CHAR_VT    = 8'd11;
   localparam logic [7:0] CHAR_FF    = 8'd12;
   localparam logic [7:0] CHAR_SPACE = " ";
   localparam logic [7:0] CHAR_PLUS  = "+";
   localparam logic [7:0] CHAR_MINUS = "-";
   localparam logic [7:0] CHAR_ZERO  = "0";
   localparam logic [7:0] CHAR_NINE  = "9";
   localparam logic [7:0] CHAR_M     = "M";
   localparam logic [7:0] CHAR_F     = "F";
   localparam logic [7:0] CHAR_B     = "B";
   localparam logic [7:0] CHAR_L     = "L";
   localparam logic [7:0] CHAR_R     = "R";
   localparam logic [7:0] CHAR_X     = "X";
   localparam logic [7:0] CHAR_Y     = "Y";
   localparam logic [7:0] CHAR_S     = "S";

   // number parser phase
   typedef enum logic [1:0] {
      PH_SKIP   = 2'd0,
      PH_SIGN   = 2'd1,
      PH_DIGITS = 2'd2,
      PH_DONE   = 2'd3
   } phase_type;

   // what a finished line asks for
   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_RAMP,
      KIND_SINGLE
   } kind_type;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_STEP,
      ST_SEND
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic line_feed;
      logic line_clear;
      logic ramp_load;
      logic single_load;
      logic div_step;
      logic ramp_step;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic     is_term;
      kind_type kind;
      logic     div_last;
      logic     last;
   } dp_status_type;

endpackage

[rtl/sdcd_ctrl.sv]
// ----------------------------------------------------------------------------
// sdcd_ctrl
// Sequencer: takes bytes, starts commands, walks divider and ramp steps.
// ----------------------------------------------------------------------------
module sdcd_ctrl
   import sdcd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands, input is open only in idle
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (status.is_term) begin
                  cmd.line_clear = 1'b1;
                  case (status.kind)
                     KIND_RAMP: begin
                        cmd.ramp_load = 1'b1;
                        state_in      = ST_DIVIDE;
                     end
                     KIND_SINGLE: begin
                        cmd.single_load = 1'b1;
                        state_in        = ST_SEND;
                     end
                     default: ;
                  endcase
               end else begin
                  cmd.line_feed = 1'b1;
               end
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            cmd.ramp_step = 1'b1;
            state_in      = ST_SEND;
         end
         ST_SEND: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = status.last ? ST_IDLE : ST_STEP;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

[rtl/sdcd_datapath.sv]
// ----------------------------------------------------------------------------
// sdcd_datapath
// Line buffer, number parser, registers, ramp divider and result register.
// ----------------------------------------------------------------------------
module sdcd_datapath
   import sdcd_pkg::*;
#(
   parameter int LINE_LIMIT = LINE_LIMIT_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]           csr_wdata,
   input  logic [7:0]           req_rx_byte,
   input  dp_cmd_type           cmd,
   output dp_status_type        status,
   output logic [7:0]           rsp_duty,
   output logic [1:0]           rsp_front_left_dir,
   output logic [1:0]           rsp_rear_left_dir,
   output logic [1:0]           rsp_front_right_dir,
   output logic [1:0]           rsp_rear_right_dir,
   output logic                 rsp_last_of_run
);

   localparam int POS_W = $clog2(LINE_LIMIT + 1);

   // configuration registers
   logic [7:0] min_pwm_ff, max_pwm_ff, turn_pwm_ff;
   logic [6:0] ramp_steps_ff;

   // line state
   logic [POS_W-1:0] pos_ff;
   logic [7:0]       lead_ff, letter_ff;
   phase_type        phase_ff;
   logic             neg_ff;
   logic [9:0]       value_ff;
   logic [7:0]       kept_ff;

   // ramp state
   logic [7:0] from_ff;
   logic       down_ff;
   logic [1:0] dir_ff;
   logic [2:0] div_cnt_ff;
   logic [6:0] rem_ff;
   logic [7:0] quo_ff;
   logic [7:0] q_ff;
   logic [6:0] r_ff;
   logic [6:0] i_ff;

   // result register
   logic [7:0] duty_ff;
   logic [1:0] fl_ff, rl_ff, fr_ff, rr_ff;
   logic       last_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         min_pwm_ff    <= MIN_PWM_RST;
         max_pwm_ff    <= MAX_PWM_RST;
         turn_pwm_ff   <= TURN_PWM_RST;
         ramp_steps_ff <= RAMP_STEPS_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MIN_PWM:    min_pwm_ff    <= csr_wdata;
            CSR_MAX_PWM:    max_pwm_ff    <= csr_wdata;
            CSR_TURN_PWM:   turn_pwm_ff   <= csr_wdata;
            CSR_RAMP_STEPS: ramp_steps_ff <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   // effective ramp length, 1 to 64
   logic [6:0] steps;
   always_comb begin
      if (ramp_steps_ff == 7'd0) begin
         steps = 7'd1;
      end else if (ramp_steps_ff > RAMP_STEPS_MAX) begin
         steps = RAMP_STEPS_MAX;
      end else begin
         steps = ramp_steps_ff;
      end
   end

   // byte classification
   logic       is_digit, is_space, is_term;
   logic [3:0] digit;
   assign is_term  = (req_rx_byte == CHAR_CR) || (req_rx_byte == CHAR_LF);
   assign is_digit = (req_rx_byte >= CHAR_ZERO) && (req_rx_byte <= CHAR_NINE);
   assign is_space = (req_rx_byte == CHAR_SPACE) || (req_rx_byte == CHAR_TAB) ||
                     (req_rx_byte == CHAR_VT) || (req_rx_byte == CHAR_FF);
   assign digit    = 4'(req_rx_byte - CHAR_ZERO);

   // saturating decimal accumulate
   logic [13:0] value_x10;
   logic [9:0]  value_next;
   assign value_x10  = {1'b0, value_ff, 3'b000} + {3'b000, value_ff, 1'b0} + {10'd0, digit};
   assign value_next = (value_x10 > {4'd0, NUM_SAT}) ? NUM_SAT : value_x10[9:0];

   // clamped target speed
   logic signed [10:0] num;
   logic [7:0]         target;
   always_comb begin
      num = neg_ff ? -$signed({1'b0, value_ff}) : $signed({1'b0, value_ff});
      if (num < $signed({3'b000, min_pwm_ff})) begin
         target = min_pwm_ff;
      end else if (num > $signed({3'b000, max_pwm_ff})) begin
         target = max_pwm_ff;
      end else begin
         target = num[7:0];
      end
   end

   // command decode of the held line
   logic line_ok;
   kind_type kind;
   assign line_ok = (lead_ff == CHAR_M) && (pos_ff >= POS_W'(3));
   always_comb begin
      kind = KIND_NONE;
      if (line_ok) begin
         case (letter_ff)
            CHAR_F, CHAR_B:                 kind = KIND_RAMP;
            CHAR_L, CHAR_R, CHAR_X, CHAR_Y,
            CHAR_S:                         kind = KIND_SINGLE;
            default:                        kind = KIND_NONE;
         endcase
      end
   end

   // line buffer and number parser
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         lead_ff   <= '0;
         letter_ff <= '0;
         phase_ff  <= PH_SKIP;
         neg_ff    <= 1'b0;
         value_ff  <= '0;
         kept_ff   <= '0;
      end else begin
         if (cmd.line_clear && pos_ff != '0) begin
            pos_ff    <= '0;
            lead_ff   <= '0;
            letter_ff <= '0;
            phase_ff  <= PH_SKIP;
            neg_ff    <= 1'b0;
            value_ff  <= '0;
         end
         if (cmd.line_feed && pos_ff < POS_W'(LINE_LIMIT)) begin
            pos_ff <= pos_ff + POS_W'(1);
            if (pos_ff == '0) begin
               lead_ff <= req_rx_byte;
            end else if (pos_ff == POS_W'(2)) begin
               letter_ff <= req_rx_byte;
            end else if (pos_ff >= POS_W'(4)) begin
               case (phase_ff)
                  PH_SKIP: begin
                     if (is_space) begin
                        phase_ff <= PH_SKIP;
                     end else if (req_rx_byte == CHAR_PLUS ||
                                  req_rx_byte == CHAR_MINUS) begin
                        neg_ff   <= (req_rx_byte == CHAR_MINUS);
                        phase_ff <= PH_SIGN;
                     end else if (!is_digit) begin
                        phase_ff <= PH_DONE;
                     end else begin
                        phase_ff <= PH_DIGITS;
                        value_ff <= {6'd0, digit};
                     end
                  end
                  PH_SIGN, PH_DIGITS: begin
                     if (!is_digit) begin
                        phase_ff <= PH_DONE;
                     end else begin
                        phase_ff <= PH_DIGITS;
                        value_ff <= value_next;
                     end
                  end
                  default: ;
               endcase
            end
         end
         // kept speed follows the command
         if (cmd.ramp_load) begin
            kept_ff <= target;
         end else if (cmd.single_load && letter_ff == CHAR_S) begin
            kept_ff <= '0;
         end
      end
   end

   // restoring divider step: |diff| / steps
   logic [7:0] div_sh;
   logic       div_ge;
   logic [7:0] div_sub;
   assign div_sh  = {rem_ff, quo_ff[7]};
   assign div_ge  = div_sh >= {1'b0, steps};
   assign div_sub = div_sh - {1'b0, steps};

   // ramp step: q += qd, r += rd with carry
   logic [7:0] r_sum;
   logic       r_carry;
   logic [8:0] q_sum;
   logic [7:0] q_next;
   logic [6:0] i_next;
   assign r_sum   = {1'b0, r_ff} + {1'b0, rem_ff};
   assign r_carry = r_sum >= {1'b0, steps};
   assign q_sum   = {1'b0, q_ff} + {1'b0, quo_ff} + {8'd0, r_carry};
   assign q_next  = q_sum[7:0];
   assign i_next  = i_ff + 7'd1;

   // step speed, clamped, then limited for drive
   logic signed [9:0] s_raw;
   logic [7:0]        s_clamp, s_duty;
   always_comb begin
      s_raw = down_ff ? $signed({2'b00, from_ff}) - $signed({2'b00, q_next})
                      : $signed({2'b00, from_ff}) + $signed({2'b00, q_next});
      if (s_raw < $signed({2'b00, min_pwm_ff})) begin
         s_clamp = min_pwm_ff;
      end else if (s_raw > $signed({2'b00, max_pwm_ff})) begin
         s_clamp = max_pwm_ff;
      end else begin
         s_clamp = s_raw[7:0];
      end
      s_duty = (s_clamp > max_pwm_ff) ? max_pwm_ff : s_clamp;
   end

   // limited duties of single commands
   logic [7:0] turn_duty, target_duty;
   assign turn_duty   = (turn_pwm_ff > max_pwm_ff) ? max_pwm_ff : turn_pwm_ff;
   assign target_duty = (target > max_pwm_ff) ? max_pwm_ff : target;

   // divider control
   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
      end else if (cmd.ramp_load) begin
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         div_cnt_ff <= div_cnt_ff + 3'd1;
      end
   end

   // ramp datapath
   always_ff @(posedge clock) begin
      if (cmd.ramp_load) begin
         from_ff <= kept_ff;
         down_ff <= target < kept_ff;
         quo_ff  <= (target < kept_ff) ? kept_ff - target : target - kept_ff;
         rem_ff  <= '0;
         q_ff    <= '0;
         r_ff    <= '0;
         i_ff    <= '0;
         dir_ff  <= (letter_ff == CHAR_F) ? DIR_FWD : DIR_BWD;
      end else if (cmd.div_step) begin
         rem_ff <= div_ge ? div_sub[6:0] : div_sh[6:0];
         quo_ff <= {quo_ff[6:0], div_ge};
      end else if (cmd.ramp_step) begin
         q_ff <= q_next;
         r_ff <= r_carry ? 7'(r_sum - {1'b0, steps}) : r_sum[6:0];
         i_ff <= i_next;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.ramp_step) begin
         duty_ff <= s_duty;
         fl_ff   <= dir_ff;
         rl_ff   <= dir_ff;
         fr_ff   <= dir_ff;
         rr_ff   <= dir_ff;
         last_ff <= (i_next == steps);
      end else if (cmd.single_load) begin
         last_ff <= 1'b1;
         case (letter_ff)
            CHAR_L: begin
               duty_ff <= turn_duty;
               {fl_ff, rl_ff, fr_ff, rr_ff} <= {DIR_BWD, DIR_BWD, DIR_FWD, DIR_FWD};
            end
            CHAR_R: begin
               duty_ff <= turn_duty;
               {fl_ff, rl_ff, fr_ff, rr_ff} <= {DIR_FWD, DIR_FWD, DIR_BWD, DIR_BWD};
            end
            CHAR_X: begin
               duty_ff <= target_duty;
               {fl_ff, rl_ff, fr_ff, rr_ff} <= {DIR_BWD, DIR_FWD, DIR_FWD, DIR_BWD};
            end
            CHAR_Y: begin
               duty_ff <= target_duty;
               {fl_ff, rl_ff, fr_ff, rr_ff} <= {DIR_FWD, DIR_BWD, DIR_BWD, DIR_FWD};
            end
            default: begin
               duty_ff <= '0;
               {fl_ff, rl_ff, fr_ff, rr_ff} <= {DIR_BRK, DIR_BRK, DIR_BRK, DIR_BRK};
            end
         endcase
      end
   end

   // status to the controller
   assign status.is_term  = is_term;
   assign status.kind     = kind;
   assign status.div_last = (div_cnt_ff == 3'd7);
   assign status.last     = last_ff;

   assign rsp_duty            = duty_ff;
   assign rsp_front_left_dir  = fl_ff;
   assign rsp_rear_left_dir   = rl_ff;
   assign rsp_front_right_dir = fr_ff;
   assign rsp_rear_right_dir  = rr_ff;
   assign rsp_last_of_run     = last_ff;

endmodule

[rtl/serial_drive_command_decoder_top.sv]
// A data byte is taken and the block stays idle, ready for the next byte.
// A CR or LF that ends a line with no command also leaves it idle. A pivot,
// strafe or brake line loads the result register and the block stalls its input
// until that one result is transferred.
// A forward or backward ramp of n steps first runs the serial divider that
// splits the speed difference by n, then computes each step in the STEP state
// and transfers it in the SEND state, which holds while the output stalls;
// input stays stalled until the last step is transferred.
// ----------------------------------------------------------------------------
// serial_drive_command_decoder_top
// Serial line decoder producing four-motor drive commands and speed ramps.
// ----------------------------------------------------------------------------
module serial_drive_command_decoder_top
   import sdcd_pkg::*;
#(
   parameter int LINE_LIMIT = LINE_LIMIT_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]           csr_wdata,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_rx_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_duty,
   output logic [1:0]           rsp_front_left_dir,
   output logic [1:0]           rsp_rear_left_dir,
   output logic [1:0]           rsp_front_right_dir,
   output logic [1:0]           rsp_rear_right_dir,
   output logic                 rsp_last_of_run
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencer
   sdcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath
   sdcd_datapath #(
      .LINE_LIMIT (LINE_LIMIT)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_rx_byte         (req_rx_byte),
      .cmd                 (cmd),
      .status              (status),
      .rsp_duty            (rsp_duty),
      .rsp_front_left_dir  (rsp_front_left_dir),
      .rsp_rear_left_dir   (rsp_rear_left_dir),
      .rsp_front_right_dir (rsp_front_right_dir),
      .rsp_rear_right_dir  (rsp_rear_right_dir),
      .rsp_last_of_run     (rsp_last_of_run)
   );

endmodule

[rtl/sdcd_checker.sv]
// ----------------------------------------------------------------------------
// sdcd_checker
// Port-level checks of the decoder's transfer ordering, bound to the top.
// ----------------------------------------------------------------------------
module sdcd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_duty,
   input logic       rsp_last_of_run
);

   // no byte is taken while a result waits
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken while a result is pending");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_duty) &&
                                 $stable(rsp_last_of_run))
      else $error("stalled result changed");

   // more results follow a non-final transfer, input stays closed
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_of_run |=> req_stall)
      else $error("input reopened inside a run");

   // after the final transfer the result channel goes quiet
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_last_of_run |=> !rsp_valid)
      else $error("result after end of run");

endmodule

bind serial_drive_command_decoder_top sdcd_checker u_sdcd_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_duty        (rsp_duty),
   .rsp_last_of_run (rsp_last_of_run)
);
